// ----- rtl/alrsc_pkg.sv -----
package alrsc_pkg;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TIMEOUT  = 3'd1,
        ST_GAP      = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_SHORT    = 3'd4,
        ST_BADSUM   = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        REG_END_CHAR      = 2'd0,
        REG_CHECKSUM_ON   = 2'd1,
        REG_TIMEOUT_TICKS = 2'd2
    } t_reg_index;

    localparam logic       KIND_PAYLOAD = 1'b0;
    localparam logic       KIND_STATUS  = 1'b1;
    localparam logic       REQ_BYTE     = 1'b0;
    localparam logic       REQ_TICK     = 1'b1;
    localparam logic [7:0] END_CHAR_RST = 8'd13;
    localparam logic [14:0] TIMEOUT_MAX = 15'h7FFF;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] out_byte;
        t_status    status;
        logic [7:0] line_length;
    } t_out_item;

    // Bit 4 set means the byte is not a hex digit.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 5'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 5'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 5'(c - 8'h57);
        end
        return v;
    endfunction

endpackage

// ----- rtl/alrsc_sum_check.sv -----
module alrsc_sum_check
    import alrsc_pkg::*;
(
    input  logic [7:0] i_hi_char,
    input  logic [7:0] i_lo_char,
    input  logic [7:0] i_sum,
    output logic       o_match
);

    logic [4:0] hi;
    logic [4:0] lo;

    always_comb begin
        hi      = hex_val(i_hi_char);
        lo      = hex_val(i_lo_char);
        o_match = !hi[4] && !lo[4] && ({hi[3:0], lo[3:0]} == i_sum);
    end

endmodule

// ----- rtl/ascii_line_receiver_sum_check.sv -----
// Deframes ASCII lines from a stream of received bytes and idle ticks. Every
// line byte is passed on as a payload beat; a line ends in one status beat
// (ok, timeout, gap, overflow, too short or checksum bad). In checksum mode
// the last two line bytes are held back and checked as a hex 8-bit sum. One
// input beat can be taken in every cycle; the only stall is a result waiting
// in the one-deep output register.

module ascii_line_receiver_sum_check
    import alrsc_pkg::*;
#(
    parameter int MAX_LINE = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_data,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_index,
    input  logic [14:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_LINE + 1);

    logic [7:0]    r_end_char;
    logic          r_checksum_on;
    logic [14:0]   r_timeout_ticks;

    logic          r_in_line,     n_in_line;
    logic [14:0]   r_idle_count,  n_idle_count;
    logic [CW-1:0] r_byte_count,  n_byte_count;
    logic [7:0]    r_running_sum, n_running_sum;
    logic [7:0]    r_held0,       n_held0;
    logic [7:0]    r_held1,       n_held1;

    logic          r_out_valid;
    t_out_item     r_out_data;

    logic          accept;
    logic          emit;
    t_out_item     result;
    logic          sum_match;
    logic [14:0]   limit;
    logic [14:0]   idle_inc;
    logic [CW-1:0] delivered;

    alrsc_sum_check u_sum_check (
        .i_hi_char (r_held0),
        .i_lo_char (r_held1),
        .i_sum     (r_running_sum),
        .o_match   (sum_match)
    );

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_char      <= END_CHAR_RST;
            r_checksum_on   <= 1'b1;
            r_timeout_ticks <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_END_CHAR:      r_end_char      <= i_cfg_data[7:0];
                REG_CHECKSUM_ON:   r_checksum_on   <= i_cfg_data[0];
                REG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        limit    = (r_timeout_ticks == '0) ? TIMEOUT_MAX : r_timeout_ticks;
        idle_inc = r_idle_count + 15'd1;
        if (r_checksum_on) begin
            delivered = (r_byte_count >= CW'(2)) ? r_byte_count - CW'(2) : '0;
        end else begin
            delivered = r_byte_count;
        end

        n_in_line     = r_in_line;
        n_idle_count  = r_idle_count;
        n_byte_count  = r_byte_count;
        n_running_sum = r_running_sum;
        n_held0       = r_held0;
        n_held1       = r_held1;
        emit          = 1'b0;
        result        = '{out_kind: KIND_STATUS, out_byte: 8'd0, status: ST_OK,
                          line_length: 8'd0};

        if (r_in_line && r_byte_count >= CW'(MAX_LINE)) begin
            emit               = 1'b1;
            result.status      = ST_OVERFLOW;
            result.line_length = 8'(delivered);
        end else if (i_in_data.req_type == REQ_TICK) begin
            if (r_in_line) begin
                emit               = 1'b1;
                result.status      = ST_GAP;
                result.line_length = 8'(delivered);
            end else if (idle_inc >= limit) begin
                emit          = 1'b1;
                result.status = ST_TIMEOUT;
                n_idle_count  = '0;
            end else begin
                n_idle_count = idle_inc;
            end
        end else if (i_in_data.rx_byte == r_end_char) begin
            emit = 1'b1;
            if (!r_checksum_on) begin
                result.line_length = 8'(r_byte_count);
            end else if (r_byte_count < CW'(2)) begin
                result.status = ST_SHORT;
            end else begin
                result.status      = sum_match ? ST_OK : ST_BADSUM;
                result.line_length = 8'(r_byte_count - CW'(2));
            end
        end else begin
            n_in_line    = 1'b1;
            n_idle_count = '0;
            n_byte_count = r_byte_count + CW'(1);
            if (r_checksum_on) begin
                if (r_byte_count < CW'(2)) begin
                    if (r_byte_count[0]) begin
                        n_held1 = i_in_data.rx_byte;
                    end else begin
                        n_held0 = i_in_data.rx_byte;
                    end
                end else begin
                    emit               = 1'b1;
                    result.out_kind    = KIND_PAYLOAD;
                    result.out_byte    = r_held0;
                    result.line_length = 8'(r_byte_count - CW'(1));
                    n_held0            = r_held1;
                    n_held1            = i_in_data.rx_byte;
                    n_running_sum      = r_running_sum + r_held0;
                end
            end else begin
                emit               = 1'b1;
                result.out_kind    = KIND_PAYLOAD;
                result.out_byte    = i_in_data.rx_byte;
                result.line_length = 8'(r_byte_count + CW'(1));
                n_running_sum      = r_running_sum + i_in_data.rx_byte;
            end
        end

        // Every status beat other than a timeout closes the line.
        if (emit && result.out_kind == KIND_STATUS && result.status != ST_TIMEOUT) begin
            n_in_line     = 1'b0;
            n_idle_count  = '0;
            n_byte_count  = '0;
            n_running_sum = '0;
            n_held0       = '0;
            n_held1       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_line     <= 1'b0;
            r_idle_count  <= '0;
            r_byte_count  <= '0;
            r_running_sum <= '0;
            r_held0       <= '0;
            r_held1       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_in_line     <= n_in_line;
                r_idle_count  <= n_idle_count;
                r_byte_count  <= n_byte_count;
                r_running_sum <= n_running_sum;
                r_held0       <= n_held0;
                r_held1       <= n_held1;
            end
            if (accept && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_out_data <= result;
        end
    end

endmodule

// ----- rtl/alrsc_checker.sv -----
module alrsc_checker
    import alrsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       o_in_ready,
    input  t_in_item   i_in_data,
    input  logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_out_item  o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input beat withdrawn or changed while waiting");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with an empty output register");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while a result beat is stalled");

    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result beat present straight after reset");

endmodule

bind ascii_line_receiver_sum_check alrsc_checker u_alrsc_checker (.*);
